[design/brbs_pkg.sv]
// ----------------------------------------------------------------------------
// brbs_pkg
// Shared types and constants for the bitmap run bounds search core.
// ----------------------------------------------------------------------------
package brbs_pkg;

    // default bitmap depth in 32-bit words
    localparam int BITMAP_WORDS_DEF = 1024;
    localparam int WORD_BITS        = 32;
    localparam int CMD_DEPTH        = 4;
    localparam int RES_DEPTH        = 2;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // input item
    typedef struct packed {
        logic        op;
        logic [9:0]  word_index;
        logic [31:0] word_data;
        logic [14:0] query_id;
    } item_t;

    // result item
    typedef struct packed {
        logic [15:0] range_from;
        logic [14:0] range_to;
        logic        fault;
    } result_t;

    // classified command from front to back
    typedef struct packed {
        logic        is_query;
        logic        wr_ok;
        logic        start_bad;
        logic        end_bad;
        logic [9:0]  start_word;
        logic [4:0]  start_bit;
        logic [9:0]  end_word;
        logic [4:0]  end_bit;
        logic [9:0]  word_index;
        logic [31:0] word_data;
    } cmd_t;

endpackage

[design/brbs_ram.sv]
// ----------------------------------------------------------------------------
// brbs_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module brbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/brbs_fifo.sv]
// ----------------------------------------------------------------------------
// brbs_fifo
// Small flop-based first-in first-out queue.
// ----------------------------------------------------------------------------
module brbs_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (PW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign dout    = data_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (PW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

[design/brbs_front.sv]
// ----------------------------------------------------------------------------
// brbs_front
// Accepts items, splits query ids into word and bit, flags out-of-range
// accesses and queues the resulting commands for the back end.
// ----------------------------------------------------------------------------
module brbs_front #(
    parameter int BITMAP_WORDS = brbs_pkg::BITMAP_WORDS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  brbs_pkg::item_t  item,
    output logic             full,
    input  logic             clearing,
    input  logic             cmd_pop,
    output brbs_pkg::cmd_t   cmd,
    output logic             cmd_empty
);

    brbs_pkg::cmd_t cmd_in;
    logic           cmd_full;
    logic [14:0]    z;
    logic [16:0]    start_word_ext;
    logic [16:0]    end_word_ext;

    assign full = cmd_full || clearing;

    // classify the incoming item
    always_comb
    begin
        z              = item.query_id - 15'd1;
        start_word_ext = 17'(z[14:5]);
        end_word_ext   = 17'(item.query_id[14:5]);

        cmd_in.is_query   = (item.op == brbs_pkg::OP_QUERY);
        cmd_in.wr_ok      = (17'(item.word_index) < 17'(BITMAP_WORDS));
        cmd_in.start_bad  = (item.query_id == '0)
                            || (start_word_ext >= 17'(BITMAP_WORDS));
        cmd_in.end_bad    = (end_word_ext >= 17'(BITMAP_WORDS));
        cmd_in.start_word = z[14:5];
        cmd_in.start_bit  = z[4:0];
        cmd_in.end_word   = item.query_id[14:5];
        cmd_in.end_bit    = item.query_id[4:0];
        cmd_in.word_index = item.word_index;
        cmd_in.word_data  = item.word_data;
    end

    // command queue between front and back
    brbs_fifo #(
        .WIDTH ($bits(brbs_pkg::cmd_t)),
        .DEPTH (brbs_pkg::CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && !full),
        .din   (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (cmd),
        .empty (cmd_empty)
    );

endmodule

[design/brbs_back.sv]
// ----------------------------------------------------------------------------
// brbs_back
// Owns the boundary bitmap RAM: clears it after reset, performs word writes
// and scans words down and up for the run bounds of each query.
// ----------------------------------------------------------------------------
module brbs_back #(
    parameter int BITMAP_WORDS = brbs_pkg::BITMAP_WORDS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  brbs_pkg::cmd_t    cmd,
    input  logic              cmd_empty,
    output logic              cmd_pop,
    output logic              clearing,
    input  logic              res_full,
    output logic              res_push,
    output brbs_pkg::result_t res
);

    localparam int AW = $clog2(BITMAP_WORDS);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_START = 2'd2;
    localparam logic [1:0] ST_END   = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic          first_reg, first_next;
    logic [4:0]    bit_reg, bit_next;
    logic [9:0]    end_word_reg, end_word_next;
    logic [4:0]    end_bit_reg, end_bit_next;
    logic          end_bad_reg, end_bad_next;
    logic [15:0]   from_reg, from_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    logic [31:0]   start_word_masked;
    logic [31:0]   end_word_masked;
    logic [4:0]    hi_bit;
    logic [4:0]    lo_bit;

    assign clearing = (state_reg == ST_CLEAR);

    // masked words for the first read of each scan
    always_comb
    begin
        start_word_masked = ram_rdata;
        end_word_masked   = ram_rdata;
        if (first_reg)
        begin
            start_word_masked = ram_rdata & 32'((33'd2 << bit_reg) - 33'd1);
            end_word_masked   = ram_rdata & (32'hFFFF_FFFF << bit_reg);
        end
    end

    // highest and lowest set bit
    always_comb
    begin
        hi_bit = '0;
        lo_bit = '0;
        for (int k = 0; k < brbs_pkg::WORD_BITS; k++)
        begin
            if (start_word_masked[k])
            begin
                hi_bit = 5'(k);
            end
        end
        for (int k = brbs_pkg::WORD_BITS - 1; k >= 0; k--)
        begin
            if (end_word_masked[k])
            begin
                lo_bit = 5'(k);
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        cur_next      = cur_reg;
        first_next    = first_reg;
        bit_next      = bit_reg;
        end_word_next = end_word_reg;
        end_bit_next  = end_bit_reg;
        end_bad_next  = end_bad_reg;
        from_next     = from_reg;

        cmd_pop   = 1'b0;
        res_push  = 1'b0;
        res       = '0;
        ram_we    = 1'b0;
        ram_waddr = AW'(cmd.word_index);
        ram_wdata = cmd.word_data;
        ram_raddr = AW'(cmd.start_word);

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(BITMAP_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop = 1'b1;
                    if (!cmd.is_query)
                    begin
                        ram_we = cmd.wr_ok;
                    end
                    else if (cmd.start_bad)
                    begin
                        res_push  = 1'b1;
                        res.fault = 1'b1;
                    end
                    else
                    begin
                        cur_next      = AW'(cmd.start_word);
                        first_next    = 1'b1;
                        bit_next      = cmd.start_bit;
                        end_word_next = cmd.end_word;
                        end_bit_next  = cmd.end_bit;
                        end_bad_next  = cmd.end_bad;
                        state_next    = ST_START;
                    end
                end
            end

            ST_START:
            begin
                first_next = 1'b0;
                if (start_word_masked != '0)
                begin
                    from_next = 16'((AW+6)'({cur_reg, hi_bit}) + (AW+6)'(1));
                    if (end_bad_reg)
                    begin
                        res_push   = 1'b1;
                        res.fault  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cur_next   = AW'(end_word_reg);
                        ram_raddr  = AW'(end_word_reg);
                        first_next = 1'b1;
                        bit_next   = end_bit_reg;
                        state_next = ST_END;
                    end
                end
                else if (cur_reg == '0)
                begin
                    res_push   = 1'b1;
                    res.fault  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cur_next  = cur_reg - AW'(1);
                    ram_raddr = cur_reg - AW'(1);
                end
            end

            ST_END:
            begin
                first_next = 1'b0;
                if (end_word_masked != '0)
                begin
                    res_push       = 1'b1;
                    res.range_from = from_reg;
                    res.range_to   = 15'({cur_reg, lo_bit});
                    state_next     = ST_IDLE;
                end
                else if (cur_reg == AW'(BITMAP_WORDS - 1))
                begin
                    res_push   = 1'b1;
                    res.fault  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cur_next  = cur_reg + AW'(1);
                    ram_raddr = cur_reg + AW'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            first_reg <= first_next;
        end
    end

    // scan payload
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        bit_reg      <= bit_next;
        end_word_reg <= end_word_next;
        end_bit_reg  <= end_bit_next;
        end_bad_reg  <= end_bad_next;
        from_reg     <= from_next;
    end

    // boundary bitmap
    brbs_ram #(
        .WIDTH (brbs_pkg::WORD_BITS),
        .DEPTH (BITMAP_WORDS)
    ) u_bitmap_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

[design/bitmap_run_bounds_search_core.sv]
// A write passes through the command queue and lands in the bitmap when the back end, in idle,
// takes it; a query is scanned down word by word for its start bound and then up for its end
// bound; an id of zero or with its start word past the bitmap gives its fault result from idle.
// The back end takes one item at a time, and a new one only back in idle; this is set by the
// single RAM read port, and the back end is held off while the result queue is full.
// Reset: asynchronous, active low; a clearing pass over all BITMAP_WORDS words holds full high.
// ----------------------------------------------------------------------------
// bitmap_run_bounds_search_core
// Boundary bitmap with word writes and run bounds queries.
// ----------------------------------------------------------------------------
module bitmap_run_bounds_search_core #(
    parameter int BITMAP_WORDS = brbs_pkg::BITMAP_WORDS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  brbs_pkg::item_t   item,
    output logic              full,
    output logic              empty,
    input  logic              pop,
    output brbs_pkg::result_t result
);

    brbs_pkg::cmd_t    cmd;
    logic              cmd_empty;
    logic              cmd_pop;
    logic              clearing;
    logic              res_full;
    logic              res_push;
    brbs_pkg::result_t res;

    // front end: accept and classify
    brbs_front #(
        .BITMAP_WORDS (BITMAP_WORDS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .clearing  (clearing),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .cmd_empty (cmd_empty)
    );

    // back end: bitmap access and scans
    brbs_back #(
        .BITMAP_WORDS (BITMAP_WORDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .clearing  (clearing),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    // result queue
    brbs_fifo #(
        .WIDTH ($bits(brbs_pkg::result_t)),
        .DEPTH (brbs_pkg::RES_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res),
        .full  (res_full),
        .pop   (pop),
        .dout  (result),
        .empty (empty)
    );

endmodule
